@@ rtl/core/lruc_pkg.sv @@
package lruc_pkg;

	localparam int unsigned TableDepth = 32;
	localparam int unsigned SlotW = 5;
	localparam int unsigned IdW = 20;
	localparam int unsigned RankW = 5;
	localparam int unsigned MaxCapacity = 16;
	localparam int unsigned KeyW = 24;

	localparam logic [0:0] RegCapacity = 1'b0;
	localparam logic [0:0] RegTableSize = 1'b1;

	typedef struct packed {
		logic [IdW-1:0] id;
		logic [RankW-1:0] rank;
	} slot_t;

	typedef struct packed {
		logic hit;
		logic [RankW-1:0] rank;
		logic evicted;
		logic [IdW-1:0] evicted_id;
	} result_t;

endpackage

@@ rtl/core/lruc_modu.sv @@
module lruc_modu (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [lruc_pkg::KeyW-1:0] key,
	input  logic [lruc_pkg::SlotW:0] t,
	output logic done,
	output logic [lruc_pkg::SlotW-1:0] h1,
	output logic [lruc_pkg::SlotW-1:0] h2
);

	// restoring remainder, one bit per cycle, for mod t and mod t-1
	logic [lruc_pkg::KeyW-1:0] key_q;
	logic [lruc_pkg::SlotW:0] r1_q, r2_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [lruc_pkg::SlotW+1:0] s1, s2;
	logic [lruc_pkg::SlotW:0] tm1;

	assign tm1 = t - 6'd1;
	assign s1 = {r1_q, key_q[lruc_pkg::KeyW-1]};
	assign s2 = {r2_q, key_q[lruc_pkg::KeyW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				key_q <= key;
				r1_q <= '0;
				r2_q <= '0;
				cnt_q <= 5'(lruc_pkg::KeyW);
			end else if (busy_q) begin
				key_q <= key_q << 1;
				r1_q <= (s1 >= {1'b0, t}) ? 6'(s1 - {1'b0, t}) : s1[lruc_pkg::SlotW:0];
				r2_q <= (s2 >= {1'b0, tm1}) ? 6'(s2 - {1'b0, tm1}) : s2[lruc_pkg::SlotW:0];
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign h1 = r1_q[lruc_pkg::SlotW-1:0];
	assign h2 = 5'(r2_q + 6'd1);

endmodule

@@ rtl/core/lru_cache_double_hash_index_core.sv @@
// LRU cache index in a double-hashed table of up to 31 slots. One id enters at a
// time and its result word comes out before the next id is taken: the key is formed,
// both hash remainders are found (one key bit a cycle), up to table_size probes of
// the slot memory run (each a read then a compare, plus a stop) and as many flag
// checks find a free slot, an aging sweep runs through all 32 slots (read, then
// modify and write back), a second sweep tombstones when an eviction occurs, and
// the result is stored, after which the output may stall. ids and ranks live in a
// synchronous memory; used and tombstone flags are flip-flops cleared at reset.
module lru_cache_double_hash_index_core (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata, // id_digits[19:0], zero fill
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // hit, rank[4:0], evicted, evicted_id[19:0], zero fill
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [4:0] cfg_data
);

	typedef enum logic [3:0] {
		IDLE, KEY, HASH, PREAD, PCHK, INS_READ, AREAD, AMOD, EREAD, EMOD,
		FINISH, OUT
	} state_t;

	localparam int unsigned SW = lruc_pkg::SlotW;
	localparam int unsigned TableDepth_m1 = lruc_pkg::TableDepth - 1;

	state_t state_q;
	logic [4:0] cap_q, tsize_q;
	logic [lruc_pkg::IdW-1:0] id_q;
	logic [lruc_pkg::KeyW-1:0] key_q;
	logic [SW:0] t_q;
	logic [SW-1:0] cap_eff;
	logic [SW:0] t_eff;
	logic [SW-1:0] h1, h2, h1_q, h2_q, pos_q, ins_q, sw_q;
	logic [SW:0] j_q;
	logic ins_ok_q, best_ok_q, hit_q;
	logic [lruc_pkg::RankW-1:0] r_q, best_rank_q;
	logic [lruc_pkg::IdW-1:0] best_id_q;
	logic [TableDepth_m1:0] used_q, tomb_q;
	lruc_pkg::slot_t mem [lruc_pkg::TableDepth];
	lruc_pkg::slot_t rd_s1, wr_d;
	logic [SW-1:0] addr;
	logic we;
	logic mod_start, mod_done;
	lruc_pkg::result_t res_q;
	logic [SW:0] nxt;
	logic [lruc_pkg::RankW-1:0] bumped;

	always_comb begin
		cap_eff = (cap_q == 5'd0) ? 5'd1 : (cap_q > 5'(lruc_pkg::MaxCapacity)) ?
			5'(lruc_pkg::MaxCapacity) : cap_q;
		t_eff = (tsize_q < 5'd3) ? 6'd3 : {1'b0, tsize_q};
	end

	function automatic logic [lruc_pkg::KeyW-1:0] make_key(input logic [19:0] d);
		logic [lruc_pkg::KeyW-1:0] k;
		k = '0;
		for (int i = 4; i >= 0; i--)
			k = 24'(k * 24'd31) + 24'({1'b0, d[4*i +: 4]} + 5'd1);
		return k;
	endfunction

	lruc_modu u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .key(key_q), .t(t_q),
		.done(mod_done), .h1(h1), .h2(h2)
	);

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wr_d;
		rd_s1 <= mem[addr];
	end

	// (pos + h2) mod t, both below t
	assign nxt = {1'b0, pos_q} + {1'b0, h2_q};
	assign bumped = (rd_s1.rank == 5'd31) ? 5'd31 : 5'(rd_s1.rank + 5'd1);

	always_comb begin
		addr = pos_q;
		we = 1'b0;
		wr_d = rd_s1;
		unique case (state_q)
			AREAD, EREAD: addr = sw_q;
			AMOD: begin
				addr = sw_q;
				if (hit_q) begin
					if (sw_q == pos_q) begin
						we = 1'b1; wr_d.rank = 5'd1;
					end else if (used_q[sw_q] && !tomb_q[sw_q] && rd_s1.rank < r_q) begin
						we = 1'b1; wr_d.rank = bumped;
					end
				end else if (!(ins_ok_q && sw_q == ins_q) && used_q[sw_q] && !tomb_q[sw_q]) begin
					we = 1'b1; wr_d.rank = bumped;
				end
			end
			EMOD: begin
				addr = sw_q;
				if (!(ins_ok_q && sw_q == ins_q) && used_q[sw_q] && !tomb_q[sw_q]
					&& rd_s1.rank > cap_eff) begin
					we = 1'b1; wr_d.rank = 5'd0;
				end
			end
			FINISH: begin
				addr = ins_q;
				we = ins_ok_q && !hit_q;
				wr_d.id = id_q; wr_d.rank = 5'd1;
			end
			default: addr = pos_q;
		endcase
	end

	assign mod_start = (state_q == KEY);
	assign s_axis_tready = (state_q == IDLE);
	assign m_axis_tvalid = (state_q == OUT);
	assign m_axis_tdata = {5'd0, res_q.evicted_id, res_q.evicted, res_q.rank, res_q.hit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cap_q <= 5'd8;
			tsize_q <= 5'd17;
			used_q <= '0;
			tomb_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == lruc_pkg::RegCapacity) cap_q <= cfg_data;
				else tsize_q <= cfg_data;
			end
			unique case (state_q)
				IDLE: if (s_axis_tvalid) begin
					id_q <= s_axis_tdata[19:0];
					key_q <= make_key(s_axis_tdata[19:0]);
					t_q <= t_eff;
					state_q <= KEY;
				end
				KEY: state_q <= HASH;
				HASH: if (mod_done) begin
					h1_q <= h1; h2_q <= h2; pos_q <= h1; j_q <= '0;
					hit_q <= 1'b0; state_q <= PREAD;
				end
				PREAD: begin
					if (j_q == t_q || !used_q[pos_q]) begin
						pos_q <= h1_q; j_q <= '0; state_q <= INS_READ;
					end else state_q <= PCHK;
				end
				PCHK: begin
					if (rd_s1.id == id_q) begin
						if (!tomb_q[pos_q]) begin
							hit_q <= 1'b1; r_q <= rd_s1.rank; sw_q <= '0;
							state_q <= AREAD;
						end else begin
							pos_q <= h1_q; j_q <= '0; state_q <= INS_READ;
						end
					end else begin
						pos_q <= (nxt >= t_q) ? SW'(nxt - t_q) : nxt[SW-1:0];
						j_q <= j_q + 6'd1;
						state_q <= PREAD;
					end
				end
				INS_READ: begin
					// free-slot search uses only the flags
					if (j_q == t_q) begin
						ins_ok_q <= 1'b0; sw_q <= '0; best_ok_q <= 1'b0; state_q <= AREAD;
					end else if (!used_q[pos_q] || tomb_q[pos_q]) begin
						ins_ok_q <= 1'b1; ins_q <= pos_q; sw_q <= '0; best_ok_q <= 1'b0;
						state_q <= AREAD;
					end else begin
						pos_q <= (nxt >= t_q) ? SW'(nxt - t_q) : nxt[SW-1:0];
						j_q <= j_q + 6'd1;
					end
				end
				AREAD: state_q <= AMOD;
				AMOD: begin
					if (!hit_q && !(ins_ok_q && sw_q == ins_q) && used_q[sw_q] && !tomb_q[sw_q]
						&& bumped > cap_eff && (!best_ok_q || bumped > best_rank_q)) begin
						best_ok_q <= 1'b1; best_rank_q <= bumped; best_id_q <= rd_s1.id;
					end
					sw_q <= sw_q + 5'd1;
					if (sw_q == 5'(TableDepth_m1)) begin
						if (hit_q) state_q <= FINISH;
						else if (best_ok_q || (!(ins_ok_q && sw_q == ins_q) && used_q[sw_q]
							&& !tomb_q[sw_q] && bumped > cap_eff)) state_q <= EREAD;
						else state_q <= FINISH;
					end else state_q <= AREAD;
				end
				EREAD: state_q <= EMOD;
				EMOD: begin
					if (!(ins_ok_q && sw_q == ins_q) && used_q[sw_q] && !tomb_q[sw_q]
						&& rd_s1.rank > cap_eff) tomb_q[sw_q] <= 1'b1;
					sw_q <= sw_q + 5'd1;
					state_q <= (sw_q == 5'(TableDepth_m1)) ? FINISH : EREAD;
				end
				FINISH: begin
					res_q.hit <= hit_q;
					res_q.rank <= hit_q ? r_q : 5'd0;
					res_q.evicted <= !hit_q && best_ok_q;
					res_q.evicted_id <= (!hit_q && best_ok_q) ? best_id_q : 20'd0;
					if (!hit_q && ins_ok_q) begin
						used_q[ins_q] <= 1'b1; tomb_q[ins_q] <= 1'b0;
					end
					state_q <= OUT;
				end
				OUT: if (m_axis_tready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

@@ sim/lru_cache_double_hash_index_core_tb.sv @@
module lru_cache_double_hash_index_core_tb;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata; // id_digits[19:0], zero fill
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [31:0] m_axis_tdata; // hit, rank[4:0], evicted, evicted_id[19:0], zero fill
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [4:0] cfg_data;

	typedef struct packed {
		logic hit;
		logic [4:0] rank;
		logic evicted;
		logic [19:0] evicted_id;
	} access_res_t;

	lru_cache_double_hash_index_core uut (.*);

	// predictor state
	logic [19:0] tbl_id [lruc_pkg::TableDepth];
	logic [4:0] tbl_rank [lruc_pkg::TableDepth];
	bit tbl_used [lruc_pkg::TableDepth];
	bit tbl_tomb [lruc_pkg::TableDepth];
	logic [4:0] cap_reg;
	logic [4:0] tsize_reg;

	logic [19:0] id_queue [$];
	access_res_t expected_q [$];
	bit failed;
	int unsigned cycles;
	int unsigned src_idle_pct;
	int unsigned dst_stall_pct;
	logic [19:0] recent_ids [$];

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [4:0] rank_bump(logic [4:0] r);
		return (r == 5'd31) ? 5'd31 : r + 5'd1;
	endfunction

	function automatic access_res_t predict_access(logic [19:0] id);
		access_res_t res;
		int unsigned t, cap, key, w, h1, h2, p, ins, best, r;
		bit found;
		res = '0;
		t = tsize_reg;
		if (t < 3) t = 3;
		if (t > lruc_pkg::TableDepth) t = lruc_pkg::TableDepth;
		cap = cap_reg;
		if (cap < 1) cap = 1;
		if (cap > lruc_pkg::MaxCapacity) cap = lruc_pkg::MaxCapacity;
		key = 0;
		w = 1;
		for (int i = 0; i < 5; i++) begin
			key += (((id >> (4 * i)) & 20'hF) + 1) * w;
			w *= 31;
		end
		h1 = key % t;
		h2 = 1 + key % (t - 1);
		p = h1;
		found = 0;
		for (int j = 0; j < t; j++) begin
			if (!tbl_used[p]) break;
			if (tbl_id[p] == id) begin
				found = 1;
				break;
			end
			p = (p + h2) % t;
		end
		if (found && !tbl_tomb[p]) begin
			r = tbl_rank[p];
			for (int s = 0; s < lruc_pkg::TableDepth; s++)
				if (tbl_used[s] && !tbl_tomb[s] && s != p && tbl_rank[s] < r)
					tbl_rank[s] = rank_bump(tbl_rank[s]);
			tbl_rank[p] = 5'd1;
			res.hit = 1'b1;
			res.rank = r[4:0];
			return res;
		end
		ins = lruc_pkg::TableDepth;
		best = lruc_pkg::TableDepth;
		p = h1;
		for (int j = 0; j < t; j++) begin
			if (!tbl_used[p] || tbl_tomb[p]) begin
				ins = p;
				break;
			end
			p = (p + h2) % t;
		end
		for (int s = 0; s < lruc_pkg::TableDepth; s++) begin
			if (s == ins || !tbl_used[s] || tbl_tomb[s]) continue;
			tbl_rank[s] = rank_bump(tbl_rank[s]);
			if (tbl_rank[s] > cap && (best == lruc_pkg::TableDepth
					|| tbl_rank[s] > tbl_rank[best]))
				best = s;
		end
		if (best != lruc_pkg::TableDepth) begin
			res.evicted = 1'b1;
			res.evicted_id = tbl_id[best];
			for (int s = 0; s < lruc_pkg::TableDepth; s++) begin
				if (s == ins || !tbl_used[s] || tbl_tomb[s]) continue;
				if (tbl_rank[s] > cap) begin
					tbl_tomb[s] = 1;
					tbl_rank[s] = 5'd0;
				end
			end
		end
		if (ins != lruc_pkg::TableDepth) begin
			tbl_id[ins] = id;
			tbl_rank[ins] = 5'd1;
			tbl_used[ins] = 1;
			tbl_tomb[ins] = 0;
		end
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(predict_access(s_axis_tdata[19:0]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (id_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'd0, id_queue.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected word %h", $time, m_axis_tdata);
					failed = 1;
				end else begin
					access_res_t e, a;
					e = expected_q.pop_front();
					a = {m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[6],
						m_axis_tdata[26:7]};
					if (a.hit !== e.hit || a.rank !== e.rank || a.evicted !== e.evicted
							|| a.evicted_id !== e.evicted_id) begin
						$display("%0t mismatch expected hit=%0d rank=%0d ev=%0d evid=%h",
							$time, e.hit, e.rank, e.evicted, e.evicted_id);
						$display("%0t          actual   hit=%0d rank=%0d ev=%0d evid=%h",
							$time, a.hit, a.rank, a.evicted, a.evicted_id);
						failed = 1;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [4:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lruc_pkg::RegCapacity)
			cap_reg = val;
		else
			tsize_reg = val;
	endtask

	task automatic drain;
		while (id_queue.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [19:0] pick_id();
		logic [19:0] v;
		if (recent_ids.size() > 0 && $urandom_range(99) < 55)
			return recent_ids[$urandom_range(recent_ids.size() - 1)];
		if ($urandom_range(9) == 0)
			v = 20'($urandom);
		else
			for (int i = 0; i < 5; i++)
				v[4*i +: 4] = 4'($urandom_range(9));
		recent_ids.push_back(v);
		if (recent_ids.size() > 24) void'(recent_ids.pop_front());
		return v;
	endfunction

	initial begin
		logic [4:0] caps [6] = '{5'd8, 5'd1, 5'd16, 5'd31, 5'd0, 5'd4};
		logic [4:0] sizes [6] = '{5'd17, 5'd3, 5'd31, 5'd2, 5'd5, 5'd13};
		int unsigned idle_src [4] = '{0, 61, 0, 61};
		int unsigned idle_dst [4] = '{0, 0, 61, 61};
		cap_reg = 5'd8;
		tsize_reg = 5'd17;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		for (int s = 0; s < lruc_pkg::TableDepth; s++) begin
			tbl_id[s] = '0;
			tbl_rank[s] = '0;
			tbl_used[s] = 0;
			tbl_tomb[s] = 0;
		end
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lruc_pkg::RegCapacity;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, non-bcd digits, hits, evictions at reset config
		id_queue = '{20'h00000, 20'h99999, 20'hFFFFF, 20'h12345, 20'h00000, 20'h99999,
			20'hABCDE, 20'h00001, 20'h00002, 20'h00003, 20'h00004, 20'h00005,
			20'h00006, 20'h12345, 20'h00000, 20'h55555, 20'h0F0F0};
		drain();
		// lower capacity so several entries go over at once
		write_reg(lruc_pkg::RegCapacity, 5'd2);
		id_queue = '{20'h77777, 20'h77777, 20'h00001, 20'h88888};
		drain();
		// tiny table fills up: no free slot
		write_reg(lruc_pkg::RegTableSize, 5'd3);
		write_reg(lruc_pkg::RegCapacity, 5'd16);
		id_queue = '{20'h11111, 20'h22222, 20'h33333, 20'h44444};
		drain();

		for (int ph = 0; ph < 24; ph++) begin
			write_reg(lruc_pkg::RegCapacity, caps[ph % 6]);
			write_reg(lruc_pkg::RegTableSize, sizes[(ph / 2) % 6]);
			if (ph % 8 == 7) begin
				src_idle_pct = 6;
				dst_stall_pct = 6;
			end else begin
				src_idle_pct = idle_src[ph % 4];
				dst_stall_pct = idle_dst[ph % 4];
			end
			for (int k = 0; k < 27; k++)
				id_queue.push_back(pick_id());
			drain();
		end

		if (!failed)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
